@@ src/utfd_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants for the byte classifier, the byte queue and the
// sequence decoder.
// -----------------------------------------------------------------------------
package utfd_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam int BYTE_WIDTH    = 8;
   localparam int CP_WIDTH      = 31;
   localparam int COUNT_WIDTH   = 3;
   localparam int PAYLOAD_WIDTH = 5;
   localparam int CONT_BITS     = 6;

   typedef enum logic [1:0] {
      KIND_ASCII,
      KIND_LEAD,
      KIND_INVALID
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [COUNT_WIDTH-1:0]     count;
      logic [PAYLOAD_WIDTH-1:0]   payload;
      logic [BYTE_WIDTH-1:0]      data;
   } entry_type;

endpackage

@@ src/utfd_front.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTF-8 byte classifier
// Sorts each incoming byte into ASCII, lead of a longer sequence or invalid
// lead, with the continuation count and lead payload bits, for the queue.
// -----------------------------------------------------------------------------
module utfd_front
   import utfd_pkg::*;
(
   input  logic                  push,
   input  logic                  full,
   input  logic [BYTE_WIDTH-1:0] byte_in,
   output logic                  wr_valid,
   output entry_type             wr_data
);

   always_comb begin
      wr_valid        = push && !full;
      wr_data.data    = byte_in;
      wr_data.kind    = KIND_INVALID;
      wr_data.count   = '0;
      wr_data.payload = '0;
      priority if (byte_in[7] == 1'b0) begin
         wr_data.kind = KIND_ASCII;
      end else if (byte_in[7:5] == 3'b110) begin
         wr_data.kind    = KIND_LEAD;
         wr_data.count   = 3'd1;
         wr_data.payload = byte_in[4:0];
      end else if (byte_in[7:4] == 4'b1110) begin
         wr_data.kind    = KIND_LEAD;
         wr_data.count   = 3'd2;
         wr_data.payload = {1'b0, byte_in[3:0]};
      end else if (byte_in[7:3] == 5'b11110) begin
         wr_data.kind    = KIND_LEAD;
         wr_data.count   = 3'd3;
         wr_data.payload = {2'b0, byte_in[2:0]};
      end else if (byte_in[7:2] == 6'b111110) begin
         wr_data.kind    = KIND_LEAD;
         wr_data.count   = 3'd4;
         wr_data.payload = {3'b0, byte_in[1:0]};
      end else if (byte_in[7:1] == 7'b1111110) begin
         wr_data.kind    = KIND_LEAD;
         wr_data.count   = 3'd5;
         wr_data.payload = {4'b0, byte_in[0]};
      end else begin
         wr_data.kind = KIND_INVALID;
      end
   end

endmodule

@@ src/utfd_queue.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTF-8 byte queue
// Short FIFO of classified bytes between the classifier and the decoder.
// -----------------------------------------------------------------------------
module utfd_queue
   import utfd_pkg::*;
#(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   input  entry_type wr_data,
   output logic      full,
   input  logic      rd_pop,
   output entry_type rd_data,
   output logic      empty
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   entry_type            mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_valid && !full;
   assign do_rd   = rd_pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ src/utfd_back.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the pending continuation count and the code point accumulator, and
// registers each finished code point or error for the result side.
// -----------------------------------------------------------------------------
module utfd_back
   import utfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  entry_type           rd_data,
   input  logic                rd_empty,
   output logic                rd_pop,
   output logic                empty,
   input  logic                pop,
   output logic [CP_WIDTH-1:0] code_point,
   output logic                error
);

   logic [COUNT_WIDTH-1:0] pending_ff, pending_in;
   logic [CP_WIDTH-1:0]    acc_ff, acc_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CP_WIDTH-1:0]    out_cp_ff, out_cp_in;
   logic                   out_err_ff, out_err_in;
   logic                   advance, emit;

   assign advance    = !rd_empty && (!out_valid_ff || pop);
   assign rd_pop     = advance;
   assign empty      = !out_valid_ff;
   assign code_point = out_cp_ff;
   assign error      = out_err_ff;

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      emit       = 1'b0;
      out_cp_in  = out_cp_ff;
      out_err_in = out_err_ff;
      if (advance) begin
         priority if (pending_ff != '0) begin
            acc_in     = {acc_ff[CP_WIDTH-CONT_BITS-1:0], rd_data.data[CONT_BITS-1:0]};
            pending_in = pending_ff - 1'b1;
            emit       = (pending_ff == 3'd1);
            out_cp_in  = acc_in;
            out_err_in = 1'b0;
         end else begin
            unique case (rd_data.kind)
               KIND_ASCII: begin
                  emit       = 1'b1;
                  out_cp_in  = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, rd_data.data};
                  out_err_in = 1'b0;
               end
               KIND_LEAD: begin
                  acc_in     = {{(CP_WIDTH-PAYLOAD_WIDTH){1'b0}}, rd_data.payload};
                  pending_in = rd_data.count;
               end
               default: begin
                  emit       = 1'b1;
                  out_cp_in  = '0;
                  out_err_in = 1'b1;
               end
            endcase
         end
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_cp_ff  <= out_cp_in;
         out_err_ff <= out_err_in;
      end
   end

endmodule

@@ src/utf8_byte_stream_decoder_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTF-8 byte stream decoder core
// Decodes sequences of one to six bytes into 31-bit code points and flags
// invalid lead bytes. After its final byte is accepted, a code point moves
// through the byte queue and the result register. The decoder takes one byte
// per cycle while no unpopped result holds it. Synchronous reset empties the
// byte queue and clears the sequence state and the result valid flag.
// -----------------------------------------------------------------------------
module utf8_byte_stream_decoder_core
   import utfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [BYTE_WIDTH-1:0] req_byte_in,
   output logic                  empty,
   input  logic                  pop,
   output logic [CP_WIDTH-1:0]   rsp_code_point,
   output logic                  rsp_error
);

   logic      wr_valid;
   entry_type wr_data;
   entry_type rd_data;
   logic      rd_pop;
   logic      rd_empty;

   utfd_front u_front (
      .push     (push),
      .full     (full),
      .byte_in  (req_byte_in),
      .wr_valid (wr_valid),
      .wr_data  (wr_data)
   );

   utfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_data  (wr_data),
      .full     (full),
      .rd_pop   (rd_pop),
      .rd_data  (rd_data),
      .empty    (rd_empty)
   );

   utfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rd_data    (rd_data),
      .rd_empty   (rd_empty),
      .rd_pop     (rd_pop),
      .empty      (empty),
      .pop        (pop),
      .code_point (rsp_code_point),
      .error      (rsp_error)
   );

endmodule

@@ src/utfd_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the top-level ports for reset behavior, result and request integrity.
// -----------------------------------------------------------------------------
module utfd_checker
   import utfd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  push,
   input logic                  full,
   input logic [BYTE_WIDTH-1:0] req_byte_in,
   input logic                  empty,
   input logic                  pop,
   input logic [CP_WIDTH-1:0]   rsp_code_point,
   input logic                  rsp_error
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input side full after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error) |-> (rsp_code_point == '0))
      else $error("error transaction carries a nonzero code point");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_code_point) && $stable(rsp_error)))
      else $error("stalled result transaction changed");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |-> !$isunknown(req_byte_in))
      else $error("unknown byte on an accepted request transaction");

endmodule

bind utf8_byte_stream_decoder_core utfd_checker u_utfd_checker (
   .clock          (clock),
   .reset          (reset),
   .push           (push),
   .full           (full),
   .req_byte_in    (req_byte_in),
   .empty          (empty),
   .pop            (pop),
   .rsp_code_point (rsp_code_point),
   .rsp_error      (rsp_error)
);
